### sv/tsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsw_pkg;

    localparam int CHAR_W      = 8;
    localparam int SEG_W       = 8;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int MAX_DIGITS  = 64;

    localparam logic [SEG_W-1:0]   POINT_BIT   = 8'b1000_0000;
    localparam logic [SEG_W-1:0]   SEG_BLANK   = 8'b0000_0000;
    localparam logic [SEG_W-1:0]   SEG_MINUS   = 8'b0100_0000;
    localparam logic [SEG_W-1:0]   SEG_UNDER   = 8'b0000_1000;
    localparam logic [SEG_W-1:0]   SEG_DEGREE  = 8'b0110_0011;
    localparam logic [COUNT_W-1:0] POS_SAT     = 7'd127;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DEGREE = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

    localparam int GLYPH_COUNT = 36;
    localparam int LETTER_BASE = 10;

    // digits 0-9 then letters a-z
    localparam logic [SEG_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h0E,
        8'h00, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h00
    };

    typedef struct packed {
        logic             is_dot;
        logic [SEG_W-1:0] glyph;
    } glyph_info_t;

endpackage

`default_nettype wire

### sv/tsw_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface tsw_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [5:0] position;
    logic [7:0] segments;
    logic       update;

    modport source (output valid, output write_valid, output position,
                    output segments, output update, input ready);
    modport sink   (input valid, input write_valid, input position,
                    input segments, input update, output ready);
endinterface

`default_nettype wire

### sv/text_to_seven_segment_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                    handshake
// in_ch     in   character[7:0], last                       valid / ready
// out_ch    out  write_valid, position[5:0], segments[7:0], valid / ready
//                update
// cfg       in   cfg_write_data[6:0] (digit_count)          cfg_write_enable
//
// one request per cycle sustained while out_ch.ready holds; an accepted
// character passes from the input register into the result register,
// which drives out_ch
// the position/glyph state updates when a character moves into the result register
// reset clears the state and sets digit_count to 4; no clearing pass
// a stall on out_ch holds the result register; the input register still
// takes one more request, then in_ch.ready drops until out_ch drains

module text_to_seven_segment_writer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tsw_in_if.sink                           in_ch,
    tsw_out_if.source                        out_ch,
    input  wire logic                        cfg_write_enable,
    input  wire logic [tsw_pkg::COUNT_W-1:0] cfg_write_data
);
    import tsw_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    // configuration register
    logic [COUNT_W-1:0] digit_count_reg;

    logic advance;
    logic in_take;

    // the input register frees up when its request moves on this cycle
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload holds while waiting, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= in_ch.character;
            last_reg <= in_ch.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= COUNT_RESET;
        end
        else if (cfg_write_enable)
        begin
            digit_count_reg <= cfg_write_data;
        end
    end

    // glyph lookup, dot handling, position update and result register
    tsw_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage_valid     (in_valid_reg),
        .stage_char      (char_reg),
        .stage_last      (last_reg),
        .digit_count     (digit_count_reg),
        .advance         (advance),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_write_valid (out_ch.write_valid),
        .out_position    (out_ch.position),
        .out_segments    (out_ch.segments),
        .out_update      (out_ch.update)
    );

    // a write never targets a position outside the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.write_valid)
            |-> ({1'b0, out_ch.position} < digit_count_reg))
        else $error("write beyond digit_count");

    // a result with no write carries zero position and segments
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.write_valid)
            |-> (out_ch.position == '0 && out_ch.segments == '0))
        else $error("idle result carries data");

    // a held input request keeps its character until it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance)
            |=> (in_valid_reg && $stable(char_reg) && $stable(last_reg)))
        else $error("input register lost a request");

    // nothing moves into the result register while it is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### sv/tsw_glyph.sv
`timescale 1ns / 1ps
`default_nettype none

module tsw_glyph (
    input  wire logic [tsw_pkg::CHAR_W-1:0] character,
    output tsw_pkg::glyph_info_t            info
);
    import tsw_pkg::*;

    logic [CHAR_W-1:0] digit_off;
    logic [CHAR_W-1:0] upper_off;
    logic [CHAR_W-1:0] lower_off;

    assign digit_off = character - CH_ZERO;
    assign upper_off = character - CH_UPPER_A + CHAR_W'(LETTER_BASE);
    assign lower_off = character - CH_LOWER_A + CHAR_W'(LETTER_BASE);

    always_comb
    begin
        info.is_dot = (character == CH_DOT);
        if (character >= CH_ZERO && character <= CH_NINE)
        begin
            info.glyph = GLYPH_TABLE[digit_off[5:0]];
        end
        else if (character >= CH_UPPER_A && character <= CH_UPPER_Z)
        begin
            info.glyph = GLYPH_TABLE[upper_off[5:0]];
        end
        else if (character >= CH_LOWER_A && character <= CH_LOWER_Z)
        begin
            info.glyph = GLYPH_TABLE[lower_off[5:0]];
        end
        else
        begin
            case (character)
                CH_MINUS:  info.glyph = SEG_MINUS;
                CH_UNDER:  info.glyph = SEG_UNDER;
                CH_DEGREE: info.glyph = SEG_DEGREE;
                default:   info.glyph = SEG_BLANK;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/tsw_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tsw_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        stage_valid,
    input  wire logic [tsw_pkg::CHAR_W-1:0]  stage_char,
    input  wire logic                        stage_last,
    input  wire logic [tsw_pkg::COUNT_W-1:0] digit_count,
    output logic                             advance,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_write_valid,
    output logic [tsw_pkg::POS_W-1:0]        out_position,
    output logic [tsw_pkg::SEG_W-1:0]        out_segments,
    output logic                             out_update
);
    import tsw_pkg::*;

    glyph_info_t info;

    logic [COUNT_W-1:0] next_position_reg, next_position_next;
    logic [SEG_W-1:0]   previous_glyph_reg, previous_glyph_next;
    logic               takes_point_reg, takes_point_next;

    logic               out_valid_reg;
    logic               write_valid_reg;
    logic [POS_W-1:0]   position_reg;
    logic [SEG_W-1:0]   segments_reg;
    logic               update_reg;

    logic [COUNT_W-1:0] wr_pos;
    logic [SEG_W-1:0]   wr_seg;
    logic               wr_ok;

    tsw_glyph u_glyph (
        .character (stage_char),
        .info      (info)
    );

    assign advance = stage_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        next_position_next  = next_position_reg;
        previous_glyph_next = previous_glyph_reg;
        takes_point_next    = takes_point_reg;
        wr_pos              = next_position_reg;
        wr_seg              = SEG_BLANK;
        if (info.is_dot && takes_point_reg)
        begin
            // light the point of the glyph just placed
            wr_pos              = (next_position_reg != '0) ?
                                  next_position_reg - COUNT_W'(1) : '0;
            wr_seg              = previous_glyph_reg | POINT_BIT;
            previous_glyph_next = wr_seg;
            takes_point_next    = 1'b0;
        end
        else
        begin
            if (info.is_dot)
            begin
                wr_seg           = (next_position_reg == '0) ? SEG_BLANK : POINT_BIT;
                takes_point_next = 1'b0;
            end
            else
            begin
                wr_seg           = info.glyph;
                takes_point_next = 1'b1;
            end
            previous_glyph_next = wr_seg;
            if (next_position_reg < POS_SAT)
            begin
                next_position_next = next_position_reg + COUNT_W'(1);
            end
        end
        if (stage_last)
        begin
            next_position_next = '0;
            takes_point_next   = 1'b0;
        end
        wr_ok = (wr_pos < digit_count) && (int'(wr_pos) < MAX_DIGITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_position_reg  <= '0;
            previous_glyph_reg <= '0;
            takes_point_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                next_position_reg  <= next_position_next;
                previous_glyph_reg <= previous_glyph_next;
                takes_point_reg    <= takes_point_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            write_valid_reg <= wr_ok;
            position_reg    <= wr_ok ? wr_pos[POS_W-1:0] : '0;
            segments_reg    <= wr_ok ? wr_seg : '0;
            update_reg      <= stage_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_write_valid = write_valid_reg;
    assign out_position    = position_reg;
    assign out_segments    = segments_reg;
    assign out_update      = update_reg;

endmodule

`default_nettype wire
